// ===== sv/wptd_pkg.sv =====
// Shared types and constants for the window pivot touch detector.
// No dependencies; imported by the RAM user modules and the top level.
`default_nettype none

package wptd_pkg;

    localparam int PRICE_W = 32;
    localparam int WIN_W   = 9;
    localparam int TOL_W   = 16;
    localparam int MIN_BARS = 3;

    localparam logic [WIN_W-1:0] DEFAULT_WINDOW = 9'd128;
    localparam logic [WIN_W-1:0] MIN_WINDOW     = 9'd2;
    localparam logic [TOL_W-1:0] DEFAULT_TOL    = 16'd3;

    // APB register select, taken from paddr[2]
    localparam logic REG_WINDOW_LENGTH = 1'b0;
    localparam logic REG_TOLERANCE     = 1'b1;

    // one stored ring entry
    typedef struct packed {
        logic [PRICE_W-1:0] high;
        logic [PRICE_W-1:0] low;
    } window_range_t;

    typedef struct packed {
        logic               touch;
        logic               ready_res;
        logic [PRICE_W-1:0] window_high;
        logic [PRICE_W-1:0] window_low;
    } result_t;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_SETUP = 5'b00010,
        ST_SCAN  = 5'b00100,
        ST_CALC  = 5'b01000,
        ST_EMIT  = 5'b10000
    } state_t;

endpackage

`default_nettype wire

// ===== sv/window_pivot_touch_detector_unit.sv =====
// Window pivot touch detector, top level.
// Depends on wptd_pkg, wptd_ram and wptd_scan.
//
// Usage:
//   Input stream (s_*): one price bar per word. s_tdata carries high, low and
//   close; s_tuser says whether the bar revises the newest stored bar.
//   Output stream (m_*): one result word per input word, in order. m_tdata
//   carries touch, window high and window low; m_tuser flags that at least
//   three bars have been seen (all data fields are zero before that).
//   APB port: window_length at 0x0, tolerance_ticks at 0x4; write only while
//   the block is idle.
// Timing:
//   Highs and lows sit in one ring RAM with a registered read. The
//   scanner reads one entry a cycle; each item goes through setup, scan,
//   calc and emit before the next one is accepted. Items arriving before
//   the third bar go from setup straight to emit, skipping scan and calc.
//   s_tready is high only while idle.
// Reset:
//   Clears pointers, bar count and output valid; registers go to 128 and 3.
//   The ring needs no clearing, since the scan only reaches written entries.
// Stall:
//   A held result sits in the output register; the next item is accepted and
//   processed, then waits for the register to drain before its own result.
`default_nettype none

module window_pivot_touch_detector_unit #(
    parameter int MAX_WINDOW = 256
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    // APB configuration port
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [2:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic      [31:0]  prdata,
    output logic              pready,
    // input stream
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [95:0]  s_tdata,   // bar_high[31:0], bar_low[63:32], bar_close[95:64]
    input  wire logic [0:0]   s_tuser,   // revises_newest[0]
    // output stream
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic      [71:0]  m_tdata,   // touch[0], window_high[32:1], window_low[64:33], zero
    output logic      [0:0]   m_tuser    // ready_res[0]
);

    import wptd_pkg::*;

    localparam int AW    = $clog2(MAX_WINDOW);
    localparam int CNT_W = $clog2(MAX_WINDOW + 2);
    localparam int CW    = (CNT_W > WIN_W) ? CNT_W : WIN_W;
    localparam logic [AW-1:0]    PTR_LAST = AW'(MAX_WINDOW - 1);
    localparam logic [CNT_W-1:0] SEEN_MAX = CNT_W'(MAX_WINDOW + 1);
    localparam logic [CW-1:0]    N_MAX    = CW'(MAX_WINDOW);

    state_t             state_reg, state_next;
    logic [WIN_W-1:0]   window_length_reg;
    logic [TOL_W-1:0]   tolerance_reg;
    logic [AW-1:0]      wp_reg, wp_next;
    logic [CNT_W-1:0]   seen_reg, seen_next;
    logic [PRICE_W-1:0] close_reg;
    result_t            res_reg, res_next;
    logic               out_valid_reg, out_valid_next;
    result_t            out_reg;

    logic               cfg_write;
    logic               in_accept;
    logic [AW-1:0]      newest;
    logic               revise;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    window_range_t      wr_data;
    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic [$bits(window_range_t)-1:0] rd_raw;
    window_range_t      scan_range;
    logic               scan_start;
    logic               scan_done;
    logic [CNT_W-1:0]   last_bar;
    logic [CW-1:0]      n_ext;
    logic [CNT_W-1:0]   scan_count;
    logic               out_load;
    logic signed [34:0] diff;
    logic [34:0]        mag;
    logic [34:0]        lim;

    // ---------------- configuration ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_length_reg <= DEFAULT_WINDOW;
            tolerance_reg     <= DEFAULT_TOL;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                REG_WINDOW_LENGTH: window_length_reg <= pwdata[WIN_W-1:0];
                REG_TOLERANCE:     tolerance_reg     <= pwdata[TOL_W-1:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_WINDOW_LENGTH: prdata = {{(32-WIN_W){1'b0}}, window_length_reg};
            REG_TOLERANCE:     prdata = {{(32-TOL_W){1'b0}}, tolerance_reg};
            default:           prdata = '0;
        endcase
    end

    // ---------------- ring write on accept ----------------
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign newest    = (wp_reg == '0) ? PTR_LAST : wp_reg - 1'b1;
    assign revise    = s_tuser[0] && (seen_reg != '0);

    assign wr_en        = in_accept;
    assign wr_addr      = revise ? newest : wp_reg;
    assign wr_data.high = s_tdata[31:0];
    assign wr_data.low  = s_tdata[63:32];

    wptd_ram #(
        .WIDTH ($bits(window_range_t)),
        .DEPTH (MAX_WINDOW)
    ) u_ring (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_raw)
    );

    // ---------------- window size ----------------
    assign last_bar = seen_reg - 1'b1;

    always_comb
    begin
        n_ext = CW'(window_length_reg);
        if (window_length_reg < MIN_WINDOW)
        begin
            n_ext = CW'(DEFAULT_WINDOW);
        end
        if (n_ext > N_MAX)
        begin
            n_ext = N_MAX;
        end
        // leave out the very first bar
        scan_count = (n_ext < CW'(last_bar)) ? CNT_W'(n_ext) : last_bar;
    end

    assign scan_start = (state_reg == ST_SETUP) && (seen_reg >= CNT_W'(MIN_BARS));

    wptd_scan #(
        .AW    (AW),
        .CNT_W (CNT_W)
    ) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (scan_start),
        .base_addr (newest),
        .last_addr (PTR_LAST),
        .count     (scan_count),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (window_range_t'(rd_raw)),
        .done      (scan_done),
        .range     (scan_range)
    );

    // ---------------- pivot test: |2C - H - L| <= 3 * tol ----------------
    assign diff = $signed({2'b00, close_reg, 1'b0})
                - $signed({3'b000, scan_range.high})
                - $signed({3'b000, scan_range.low});
    assign mag  = diff[34] ? 35'(-diff) : 35'(diff);
    assign lim  = {19'b0, tolerance_reg} + {18'b0, tolerance_reg, 1'b0};

    // ---------------- control ----------------
    assign out_load = (state_reg == ST_EMIT) && (!out_valid_reg || m_tready);

    always_comb
    begin
        state_next     = state_reg;
        wp_next        = wp_reg;
        seen_next      = seen_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (!revise)
                    begin
                        wp_next = (wp_reg == PTR_LAST) ? '0 : wp_reg + 1'b1;
                        if (seen_reg != SEEN_MAX)
                        begin
                            seen_next = seen_reg + 1'b1;
                        end
                    end
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                if (scan_start)
                begin
                    state_next = ST_SCAN;
                end
                else
                begin
                    res_next   = '0;
                    state_next = ST_EMIT;
                end
            end
            ST_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = ST_CALC;
                end
            end
            ST_CALC:
            begin
                res_next.touch       = (mag <= lim);
                res_next.ready_res   = 1'b1;
                res_next.window_high = scan_range.high;
                res_next.window_low  = scan_range.low;
                state_next           = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wp_reg        <= '0;
            seen_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wp_reg        <= wp_next;
            seen_reg      <= seen_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        if (in_accept)
        begin
            close_reg <= s_tdata[95:64];
        end
        if (out_load)
        begin
            out_reg <= res_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b0, out_reg.window_low, out_reg.window_high, out_reg.touch};
    assign m_tuser  = out_reg.ready_res;

endmodule

`default_nettype wire

// ===== sv/wptd_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module wptd_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== sv/wptd_scan.sv =====
// Window scanner: walks the ring backward from the newest entry, one read a
// cycle, and folds highest high and lowest low. Depends on wptd_pkg.
`default_nettype none

module wptd_scan #(
    parameter int AW    = 8,
    parameter int CNT_W = 9
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [AW-1:0]                 base_addr,
    input  wire logic [AW-1:0]                 last_addr,
    input  wire logic [CNT_W-1:0]              count,
    output logic                               rd_en,
    output logic      [AW-1:0]                 rd_addr,
    input  wire wptd_pkg::window_range_t       rd_data,
    output logic                               done,
    output wptd_pkg::window_range_t            range
);

    import wptd_pkg::*;

    logic             busy_reg, busy_next;
    logic             pend_reg, pend_next;
    logic [CNT_W-1:0] left_reg, left_next;
    logic [AW-1:0]    addr_reg, addr_next;
    window_range_t    acc_reg, acc_next;

    assign rd_en   = busy_reg && (left_reg != '0);
    assign rd_addr = addr_reg;
    assign done    = busy_reg && (left_reg == '0) && !pend_reg;
    assign range   = acc_reg;

    always_comb
    begin
        busy_next = busy_reg;
        pend_next = rd_en;
        left_next = left_reg;
        addr_next = addr_reg;
        acc_next  = acc_reg;
        if (start)
        begin
            busy_next     = 1'b1;
            pend_next     = 1'b0;
            left_next     = count;
            addr_next     = base_addr;
            acc_next.high = '0;
            acc_next.low  = '1;
        end
        else
        begin
            if (rd_en)
            begin
                left_next = left_reg - 1'b1;
                // step backward around the ring
                addr_next = (addr_reg == '0) ? last_addr : addr_reg - 1'b1;
            end
            if (pend_reg)
            begin
                if (rd_data.high > acc_reg.high)
                begin
                    acc_next.high = rd_data.high;
                end
                if (rd_data.low < acc_reg.low)
                begin
                    acc_next.low = rd_data.low;
                end
            end
            if (done)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            pend_reg <= 1'b0;
            left_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            pend_reg <= pend_next;
            left_reg <= left_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg <= addr_next;
        acc_reg  <= acc_next;
    end

endmodule

`default_nettype wire

// ===== tb/sv/tb_window_pivot_touch_detector_unit.sv =====
// Self-checking bench for window_pivot_touch_detector_unit: drives price bars on
// the input stream, programs window and tolerance over APB, checks every result word.
// Depends on wptd_pkg and the unit itself.
`default_nettype none

module tb_window_pivot_touch_detector_unit;

    timeunit 1ns;
    timeprecision 1ps;

    import wptd_pkg::*;

    localparam int      RING_DEPTH     = 256;
    localparam int      CLK_PERIOD     = 12;
    localparam int      LONG_HOLD      = 1500;
    localparam longint  TIMEOUT_CYCLES = 3_000_000;

    // Mirror of the unit: ring of highs and lows, window scan, pivot test.
    class touch_scoreboard;
        logic [PRICE_W-1:0] highs [RING_DEPTH];
        logic [PRICE_W-1:0] lows  [RING_DEPTH];
        int unsigned        wr_ptr;
        int unsigned        bars_seen;
        int unsigned        win_len;
        int unsigned        tol;
        result_t            pending [$];
        int unsigned        errors;

        function new();
            wr_ptr    = 0;
            bars_seen = 0;
            win_len   = 32'(DEFAULT_WINDOW);
            tol       = 32'(DEFAULT_TOL);
            errors    = 0;
        endfunction

        function void set_reg(input logic sel, input logic [31:0] value);
            if (sel == REG_WINDOW_LENGTH)
                win_len = 32'(value[WIN_W-1:0]);
            else
                tol = 32'(value[TOL_W-1:0]);
        endfunction

        function void note_bar(input logic [PRICE_W-1:0] hi, input logic [PRICE_W-1:0] lo,
                               input logic [PRICE_W-1:0] cl, input logic revise);
            int unsigned        slot;
            int unsigned        span;
            int unsigned        count;
            logic [PRICE_W-1:0] wh;
            logic [PRICE_W-1:0] wl;
            longint             gap;
            result_t            want;

            if (revise && bars_seen > 0) begin
                slot = (wr_ptr + RING_DEPTH - 1) % RING_DEPTH;
                highs[slot] = hi;
                lows[slot]  = lo;
            end
            else begin
                highs[wr_ptr] = hi;
                lows[wr_ptr]  = lo;
                wr_ptr = (wr_ptr + 1) % RING_DEPTH;
                if (bars_seen < RING_DEPTH + 1)
                    bars_seen++;
            end

            want = '0;
            if (bars_seen >= MIN_BARS) begin
                span = win_len;
                if (span < MIN_WINDOW)
                    span = 32'(DEFAULT_WINDOW);
                if (span > RING_DEPTH)
                    span = RING_DEPTH;
                // the oldest bar ever seen stays out of the window
                count = (span < bars_seen - 1) ? span : bars_seen - 1;
                wh   = '0;
                wl   = '1;
                slot = (wr_ptr + RING_DEPTH - 1) % RING_DEPTH;
                for (int k = 0; k < count; k++) begin
                    if (highs[slot] > wh)
                        wh = highs[slot];
                    if (lows[slot] < wl)
                        wl = lows[slot];
                    slot = (slot + RING_DEPTH - 1) % RING_DEPTH;
                end
                gap = 2 * longint'({32'd0, cl}) - longint'({32'd0, wh})
                      - longint'({32'd0, wl});
                if (gap < 0)
                    gap = -gap;
                want.touch       = (gap <= 3 * longint'(tol));
                want.ready_res   = 1'b1;
                want.window_high = wh;
                want.window_low  = wl;
            end
            pending.push_back(want);
        endfunction

        function void compare_field(input string name, input logic [31:0] want,
                                    input logic [31:0] got);
            if (got !== want) begin
                errors++;
                $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            end
        endfunction

        function void check_result(input result_t got);
            result_t want;
            if (pending.size() == 0) begin
                errors++;
                $display("%0t ns: result word with nothing expected, expected none, actual %0h",
                         $time, got);
                return;
            end
            want = pending.pop_front();
            compare_field("touch", 32'(want.touch), 32'(got.touch));
            compare_field("ready_res", 32'(want.ready_res), 32'(got.ready_res));
            compare_field("window_high", want.window_high, got.window_high);
            compare_field("window_low", want.window_low, got.window_low);
        endfunction
    endclass

    logic         clk      = 1'b0;
    logic         rst_n    = 1'b0;
    logic         psel     = 1'b0;
    logic         penable  = 1'b0;
    logic         pwrite   = 1'b0;
    logic [2:0]   paddr    = '0;
    logic [31:0]  pwdata   = '0;
    logic [31:0]  prdata;
    logic         pready;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [95:0]  s_tdata  = '0;    // bar_high[31:0], bar_low[63:32], bar_close[95:64]
    logic [0:0]   s_tuser  = '0;    // revises_newest[0]
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [71:0]  m_tdata;          // touch[0], window_high[32:1], window_low[64:33], zero
    logic [0:0]   m_tuser;          // ready_res[0]

    touch_scoreboard board = new();

    int unsigned  src_idle_pct   = 0;
    int unsigned  sink_stall_pct = 0;
    bit           long_hold_req  = 1'b0;
    longint       price_level    = 64'd50_000_000;

    window_pivot_touch_detector_unit #(
        .MAX_WINDOW(RING_DEPTH)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    initial
    begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("RESULT: ERROR");
        $finish;
    end

    always @(posedge clk)
    begin : result_monitor
        result_t got;
        if (rst_n && m_tvalid && m_tready) begin
            got.touch       = m_tdata[0];
            got.window_high = m_tdata[32:1];
            got.window_low  = m_tdata[64:33];
            got.ready_res   = m_tuser[0];
            board.check_result(got);
        end
    end

    // Result side: random back-pressure bursts, plus one long hold on request.
    initial
    begin : result_sink
        wait (rst_n);
        forever begin
            @(posedge clk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                m_tready <= 1'b1;
            end
            else if (sink_stall_pct != 0 && $urandom_range(0, 99) < sink_stall_pct) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge clk);
                m_tready <= 1'b1;
            end
            else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic write_reg(input logic sel, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        board.set_reg(sel, value);
    endtask

    task automatic send_bar(input logic [31:0] hi, input logic [31:0] lo,
                            input logic [31:0] cl, input logic revise);
        if (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {cl, lo, hi};
        s_tuser  <= revise;
        do @(posedge clk); while (!s_tready);
        board.note_bar(hi, lo, cl, revise);
    endtask

    task automatic wait_drained();
        while (board.pending.size() != 0)
            @(posedge clk);
    endtask

    // One setting of the registers, then a stream of bars from a slow random walk
    // with some raw noise mixed in.
    task automatic run_phase(input int unsigned win, input int unsigned tol_ticks,
                             input int unsigned n_bars, input int unsigned idle_pct,
                             input int unsigned stall_pct, input int unsigned noise_pct,
                             input int hold_at);
        logic [31:0] hi;
        logic [31:0] lo;
        logic [31:0] cl;
        logic        revise;

        wait_drained();
        write_reg(REG_WINDOW_LENGTH, win);
        write_reg(REG_TOLERANCE, tol_ticks);
        src_idle_pct   = idle_pct;
        sink_stall_pct = stall_pct;
        price_level    = longint'($urandom_range(1000, 32'hFFFF_0000));
        for (int k = 0; k < n_bars; k++) begin
            if (k == hold_at)
                long_hold_req = 1'b1;
            if ($urandom_range(0, 99) < noise_pct) begin
                hi     = $urandom;
                lo     = $urandom;
                cl     = $urandom;
                revise = 1'($urandom_range(0, 1));
            end
            else begin
                price_level += longint'($urandom_range(0, 40)) - 20;
                if (price_level < 200)
                    price_level = 200;
                if (price_level > 64'hFFFF_FF00)
                    price_level = 64'hFFFF_FF00;
                hi     = 32'(price_level + longint'($urandom_range(0, 60)));
                lo     = 32'(price_level - longint'($urandom_range(0, 60)));
                cl     = lo + $urandom_range(0, hi - lo);
                revise = ($urandom_range(0, 99) < 20);
            end
            send_bar(hi, lo, cl, revise);
        end
        s_tvalid <= 1'b0;
    endtask

    initial
    begin : stimulus
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: revision with nothing stored, warm-up, extreme prices
        send_bar(32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1);
        send_bar(32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
        send_bar(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1);
        send_bar(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0);
        send_bar(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        send_bar(32'hFFFF_FFFF, 32'h0000_0000, 32'h7FFF_FFFF, 1'b0);
        send_bar(32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000, 1'b0);
        send_bar(32'hFFFF_FFFF, 32'h0000_0000, 32'h8000_0000, 1'b1);
        s_tvalid <= 1'b0;

        // two-bar window, limit 15: hit the touch boundary from both sides
        wait_drained();
        write_reg(REG_WINDOW_LENGTH, 32'd2);
        write_reg(REG_TOLERANCE, 32'd5);
        send_bar(32'd110, 32'd91, 32'd100, 1'b0);
        send_bar(32'd110, 32'd91, 32'd108, 1'b0);
        send_bar(32'd110, 32'd91, 32'd109, 1'b0);
        send_bar(32'd110, 32'd91, 32'd93, 1'b0);
        send_bar(32'd110, 32'd91, 32'd92, 1'b0);
        send_bar(32'd120, 32'd91, 32'd108, 1'b1);
        send_bar(32'd110, 32'd91, 32'd108, 1'b0);
        send_bar(32'd110, 32'd91, 32'd108, 1'b0);
        s_tvalid <= 1'b0;

        //        win  tol    bars idle stall noise hold
        run_phase(2,   0,     250, 10,  10,   10,   -1);
        run_phase(5,   65535, 150, 30,  0,    10,   -1);
        run_phase(0,   40,    60,  0,   30,   5,    -1);
        run_phase(1,   20,    40,  20,  20,   5,    -1);
        run_phase(511, 100,   60,  10,  10,   5,    -1);
        run_phase(256, 60,    40,  0,   10,   5,    -1);
        run_phase(257, 30,    30,  10,  0,    5,    -1);
        run_phase(4,   $urandom_range(0, 300), 300, 15, 15, 10, 120);
        run_phase(8,   $urandom_range(0, 300), 300, 0,  30, 10, -1);
        run_phase(16,  $urandom_range(0, 300), 250, 30, 0,  10, -1);
        run_phase(32,  $urandom_range(0, 300), 150, 10, 10, 10, -1);
        run_phase(3,   $urandom_range(0, 300), 200, 0,  0,  10, -1);

        wait_drained();
        repeat (RING_DEPTH + 8) @(posedge clk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire
